/* rtl/core/lqmc_pkg.sv */
package lqmc_pkg;

    localparam int TIME_W = 16;

    localparam logic [TIME_W-1:0] STEADY_PERIOD_MS = 16'd10000;
    localparam logic [TIME_W-1:0] QUICK_DROP_MS    = 16'd10000;
    localparam logic [TIME_W-1:0] DELAY_MAX_MS     = 16'd60000;
    localparam logic [TIME_W-1:0] DELAY_MIN_MS     = 16'd1000;
    localparam logic [TIME_W-1:0] DELAY_RESET_MS   = 16'd30000;
    localparam logic [TIME_W-1:0] TIMER_MAX        = 16'hFFFF;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET_MS       = 16'd10000;
    localparam logic [TIME_W-1:0] GOOD_INTERVAL_RESET_MS = 16'd33;
    localparam logic [TIME_W-1:0] BAD_INTERVAL_RESET_MS  = 16'd100;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // register index codes (byte address 4*index)
    localparam logic [1:0] REG_TIMEOUT       = 2'd0;
    localparam logic [1:0] REG_GOOD_INTERVAL = 2'd1;
    localparam logic [1:0] REG_BAD_INTERVAL  = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] timeout_ms;
        logic [TIME_W-1:0] good_send_interval_ms;
        logic [TIME_W-1:0] bad_send_interval_ms;
    } lqmc_cfg_t;

    // saturating timer add
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TIME_W] ? TIMER_MAX : sum[TIME_W-1:0];
    endfunction

endpackage

/* rtl/core/lqmc_in_if.sv */
interface lqmc_in_if;
    import lqmc_pkg::*;

    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] elapsed_ms;
    logic [TIME_W-1:0] since_receive_ms;
    logic              rtt_good;

    modport source (output valid, output elapsed_ms, output since_receive_ms,
                    output rtt_good, input ready);
    modport sink   (input valid, input elapsed_ms, input since_receive_ms,
                    input rtt_good, output ready);
endinterface

/* rtl/core/lqmc_out_if.sv */
interface lqmc_out_if;
    logic valid;
    logic ready;
    logic timed_out;
    logic send_due;
    logic good_mode;

    modport source (output valid, output timed_out, output send_due,
                    output good_mode, input ready);
    modport sink   (input valid, input timed_out, input send_due,
                    input good_mode, output ready);
endinterface

/* rtl/core/link_quality_mode_controller.sv */
// An accepted beat yields its result beat after the input register, then the
// result register, and waits longer while the output is stalled.
// Throughput: one beat per cycle while the output is not stalled; the mode
// state updates between the two registers, so ticks may follow back to back.
// Reset (rst_n, asynchronous, active low): bad mode, return delay 30000 ms,
// all timers zero, registers at their reset values, both stages empty.
module link_quality_mode_controller
    import lqmc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    lqmc_in_if.sink            in_ch,
    lqmc_out_if.source         out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    lqmc_cfg_t cfg;

    lqmc_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input stage
    logic              in_valid_reg;
    logic [TIME_W-1:0] elapsed_reg;
    logic [TIME_W-1:0] silent_reg;
    logic              rtt_good_reg;

    // mode state
    logic              good_reg,   good_next;
    logic [TIME_W-1:0] delay_reg,  delay_next;
    logic [TIME_W-1:0] steady_reg, steady_next;
    logic [TIME_W-1:0] switch_reg, switch_next;
    logic [TIME_W-1:0] send_reg,   send_next;

    // result stage
    logic out_valid_reg;
    logic timed_out_reg, timed_out_next;
    logic send_due_reg,  send_due_next;
    logic good_mode_reg;

    logic out_free;
    logic advance;

    assign out_free    = !out_valid_reg || out_ch.ready;
    assign advance     = in_valid_reg && out_free;
    assign in_ch.ready = !in_valid_reg || out_free;

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.timed_out = timed_out_reg;
    assign out_ch.send_due  = send_due_reg;
    assign out_ch.good_mode = good_mode_reg;

    // capture the input beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            elapsed_reg  <= in_ch.elapsed_ms;
            silent_reg   <= in_ch.since_receive_ms;
            rtt_good_reg <= in_ch.rtt_good;
        end
    end

    // mode update for one tick
    always_comb
    begin
        logic [TIME_W-1:0] st_adv;
        logic [TIME_W-1:0] ss_adv;
        logic [TIME_W-1:0] snd_adv;
        logic [TIME_W:0]   dbl;
        logic [TIME_W-1:0] half;
        logic [TIME_W-1:0] interval;

        st_adv  = sat_add(steady_reg, elapsed_reg);
        ss_adv  = sat_add(switch_reg, elapsed_reg);
        snd_adv = sat_add(send_reg, elapsed_reg);
        dbl     = {delay_reg, 1'b0};
        half    = {1'b0, delay_reg[TIME_W-1:1]};

        good_next      = good_reg;
        delay_next     = delay_reg;
        steady_next    = steady_reg;
        switch_next    = switch_reg;
        send_next      = send_reg;
        timed_out_next = 1'b0;
        send_due_next  = 1'b0;
        interval       = cfg.bad_send_interval_ms;

        if (silent_reg >= cfg.timeout_ms)
        begin
            // silent too long: report and hold all state
            timed_out_next = 1'b1;
        end
        else
        begin
            steady_next = st_adv;
            switch_next = ss_adv;

            if (good_reg && !rtt_good_reg)
            begin
                // drop to bad mode, back off if the good spell was short
                good_next = 1'b0;
                if (ss_adv <= QUICK_DROP_MS)
                begin
                    delay_next = (dbl > {1'b0, DELAY_MAX_MS}) ? DELAY_MAX_MS
                                                              : dbl[TIME_W-1:0];
                end
                switch_next = '0;
            end
            else if (good_reg)
            begin
                // steady good mode shortens the return delay
                if (st_adv >= STEADY_PERIOD_MS)
                begin
                    steady_next = '0;
                    delay_next  = (half < DELAY_MIN_MS) ? DELAY_MIN_MS : half;
                end
            end
            else if (rtt_good_reg)
            begin
                // return to good mode once the delay has passed
                if (ss_adv >= delay_reg)
                begin
                    steady_next = '0;
                    switch_next = '0;
                    good_next   = 1'b1;
                end
            end
            else
            begin
                switch_next = '0;
            end

            // send timer against the interval of the new mode
            interval  = good_next ? cfg.good_send_interval_ms
                                  : cfg.bad_send_interval_ms;
            send_next = snd_adv;
            if (snd_adv >= interval)
            begin
                send_next     = '0;
                send_due_next = 1'b1;
            end
        end
    end

    // commit state on each advancing beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            good_reg   <= 1'b0;
            delay_reg  <= DELAY_RESET_MS;
            steady_reg <= '0;
            switch_reg <= '0;
            send_reg   <= '0;
        end
        else if (advance)
        begin
            good_reg   <= good_next;
            delay_reg  <= delay_next;
            steady_reg <= steady_next;
            switch_reg <= switch_next;
            send_reg   <= send_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            timed_out_reg <= timed_out_next;
            send_due_reg  <= send_due_next;
            good_mode_reg <= good_next;
        end
    end

    // return delay stays between floor and cap
    a_delay_range: assert property (@(posedge clk) disable iff (!rst_n)
        delay_reg >= DELAY_MIN_MS && delay_reg <= DELAY_MAX_MS)
        else $error("return delay out of range");

    // a timed-out tick leaves the mode state alone
    a_timeout_hold: assert property (@(posedge clk) disable iff (!rst_n)
        advance && timed_out_next |=>
            $stable(good_reg) && $stable(delay_reg) && $stable(send_reg))
        else $error("state changed on timed-out tick");

    // good mode is entered only on a good round trip
    a_enter_good: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(good_reg) |-> $past(rtt_good_reg) && $past(advance))
        else $error("entered good mode without good round trip");

    // a stalled result keeps the pending input beat
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !out_ch.ready |=> in_valid_reg)
        else $error("input beat lost under output stall");

endmodule

/* rtl/core/lqmc_apb_regs.sv */
module lqmc_apb_regs
    import lqmc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output lqmc_cfg_t          cfg
);

    lqmc_cfg_t  cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // write registers on the access phase, ignore unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ms            <= TIMEOUT_RESET_MS;
            cfg_reg.good_send_interval_ms <= GOOD_INTERVAL_RESET_MS;
            cfg_reg.bad_send_interval_ms  <= BAD_INTERVAL_RESET_MS;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_TIMEOUT:       cfg_reg.timeout_ms            <= pwdata[TIME_W-1:0];
                REG_GOOD_INTERVAL: cfg_reg.good_send_interval_ms <= pwdata[TIME_W-1:0];
                REG_BAD_INTERVAL:  cfg_reg.bad_send_interval_ms  <= pwdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (reg_idx)
            REG_TIMEOUT:       prdata = {{(PDATA_W-TIME_W){1'b0}}, cfg_reg.timeout_ms};
            REG_GOOD_INTERVAL: prdata = {{(PDATA_W-TIME_W){1'b0}},
                                         cfg_reg.good_send_interval_ms};
            REG_BAD_INTERVAL:  prdata = {{(PDATA_W-TIME_W){1'b0}},
                                         cfg_reg.bad_send_interval_ms};
            default:           prdata = '0;
        endcase
    end

endmodule
